[hw/rtl/sobel_edge_magnitude_filter_macros.svh]
// Assertion shorthands for the edge filter checkers.
`ifndef SOBEL_EDGE_MAGNITUDE_FILTER_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_FILTER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SEM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sem: property violated");

// Next-cycle implication.
`define SEM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sem: property violated");

`endif

[hw/rtl/sem_pkg.sv]
`timescale 1ns / 1ps
package sem_pkg;

  localparam int PIX_W     = 33;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_SENS   = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_CALC
  } sem_state_e;

  // window[row*3+col], row 0 on top, col 0 on the left; bit 32 is the select flag
  typedef logic [8:0][PIX_W-1:0] win_t;
  typedef logic [8:0][7:0]       chan_win_t;

  typedef struct packed {
    logic shift;
    logic wr;
    logic first;
    logic top_mid;
    logic bot_mid;
  } lb_ctrl_t;

  // Window shifted once more with its right column replicated (last pixel of a row).
  function automatic win_t edge_right(input win_t w);
    win_t q;
    for (int r = 0; r < 3; r++) begin
      q[r*3]   = w[r*3+1];
      q[r*3+1] = w[r*3+2];
      q[r*3+2] = w[r*3+2];
    end
    return q;
  endfunction

endpackage

[hw/rtl/sem_if.sv]
`timescale 1ns / 1ps
interface sem_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] pixel_in;
  logic        selected;

  modport source (output valid, output opcode, output pixel_in, output selected, input ready);
  modport sink   (input valid, input opcode, input pixel_in, input selected, output ready);
endinterface

interface sem_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        last_of_frame;

  modport source (output valid, output pixel_out, output last_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

[hw/rtl/sem_line_buf.sv]
`timescale 1ns / 1ps
module sem_line_buf
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [PIX_W-1:0] px_i,
  input  lb_ctrl_t         ctrl_i,
  output win_t             win_o
);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] mid_mem   [MAX_WIDTH];
  logic [PIX_W-1:0] up_rd_q, mid_rd_q;
  logic [2:0][PIX_W-1:0] col;
  win_t win_q, win_d;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_rd_q  <= upper_mem[rd_addr_i];
      mid_rd_q <= mid_mem[rd_addr_i];
    end
    if (ctrl_i.wr) begin
      upper_mem[wr_addr_i] <= mid_rd_q;
      mid_mem[wr_addr_i]   <= px_i;
    end
  end

  always_comb begin
    col[0] = ctrl_i.top_mid ? mid_rd_q : up_rd_q;
    col[1] = mid_rd_q;
    col[2] = ctrl_i.bot_mid ? mid_rd_q : px_i;
    win_d  = win_q;
    if (ctrl_i.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r*3]   = ctrl_i.first ? col[r] : win_q[r*3+1];
        win_d[r*3+1] = ctrl_i.first ? col[r] : win_q[r*3+2];
        win_d[r*3+2] = col[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  assign win_o = win_q;

endmodule

[hw/rtl/sem_lane.sv]
`timescale 1ns / 1ps
module sem_lane
  import sem_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  chan_win_t chan_i,
  input  logic [3:0] sens_i,
  output logic [7:0] mag_o,
  output logic      done_o
);

  localparam logic [3:0] STEP_LAST = 4'd9;

  logic signed [11:0] e [9];
  logic signed [11:0] gx_d, gy_d, gx_q, gy_q;
  logic signed [23:0] sqx, sqy;
  logic [20:0] s_q;
  logic [7:0]  kk_q;
  logic [28:0] v_full;
  logic [15:0] v_q;
  logic        sat_q;
  logic [7:0]  root_q, bit_m, t;
  logic [15:0] tt;
  logic [3:0]  step_q;
  logic        busy_q, done_q;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = $signed({4'b0, chan_i[i]});
    end
    gx_d = e[2] + e[8] + (e[5] <<< 1) - e[0] - e[6] - (e[3] <<< 1);
    gy_d = e[6] + e[8] + (e[7] <<< 1) - e[0] - e[2] - (e[1] <<< 1);
    sqx    = gx_q * gx_q;
    sqy    = gy_q * gy_q;
    v_full = 29'(s_q) * 29'(kk_q);
    bit_m  = 8'h80 >> 3'(step_q - 4'd2);
    t      = root_q | bit_m;
    tt     = 16'(t) * 16'(t);
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
      kk_q <= 8'(sens_i) * 8'(sens_i);
    end
    if (busy_q && step_q == 4'd0) begin
      s_q <= 21'(sqx[20:0]) + 21'(sqy[20:0]);
    end
    if (busy_q && step_q == 4'd1) begin
      v_q   <= v_full[17:2];
      sat_q <= |v_full[28:18];
      root_q <= '0;
    end
    if (busy_q && step_q >= 4'd2 && tt <= v_q) begin
      root_q <= t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 4'd1;
      if (step_q == STEP_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign mag_o  = sat_q ? 8'hFF : root_q;
  assign done_o = done_q;

endmodule

[hw/rtl/sobel_edge_magnitude_filter.sv]
// 3x3 Sobel edge magnitude on an ARGB raster stream.
// in_if carries one item per transfer: opcode (pixel or flush tick), the
// pixel and its selection flag. out_if returns pixel_out and last_of_frame.
// Set image_width, image_height and sensitivity through cfg_we_i/cfg_index_i/
// cfg_data_i between frames. After the last pixel of a frame send
// image_width+1 flush ticks; the last of them returns the final pixel.
// A result comes back one row plus one pixel after its input pixel.
// The block works on one item at a time. An item that makes a result is
// worked on by the three channel lanes (one that completes the row above
// starts them from ST_LOAD and skips ST_START): gradient, square, gain
// multiply, then a bit-per-cycle square root. An item with no result
// passes through ST_LOAD only; an ignored item is taken in ST_IDLE alone.
// Reset clears the counters, the window and the output valid flag and loads
// the default geometry 640x480, sensitivity 5. Line stores need no clearing.
// If out_if stalls, the finished result holds in the output register while
// the next item is already accepted and worked on.
`timescale 1ns / 1ps
module sobel_edge_magnitude_filter
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sem_in_if.sink               in_if,
  sem_out_if.source            out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(MAX_WIDTH + 2);

  sem_state_e state_q, state_d;

  logic [11:0] width_q;
  logic [15:0] height_q;
  logic [3:0]  sens_q;

  logic [CW-1:0] col_q;
  logic [15:0]   row_q;
  logic [PW-1:0] pend_q;

  logic [CW-1:0] w;
  logic [15:0]   h;
  logic [AW-1:0] c;
  logic          fire, flush_in, ignore, final_in;

  logic [AW-1:0]    addr_q;
  logic [PIX_W-1:0] px_q, ctr_q;
  logic flush_q, first_q, topm_q, res_new_q, res_edge_q, edge_q, last_q;

  logic       in_ready, start, sel_edge;
  lb_ctrl_t   lb_ctrl;
  win_t       win, fwin;
  logic [2:0][7:0] mag;
  logic [2:0] done;
  logic       out_free, out_load;

  logic        out_valid_q;
  logic [31:0] out_pix_q;
  logic        out_last_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd640;
      height_q <= 16'd480;
      sens_q   <= 4'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i[11:0];
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_SENS:   sens_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w = CW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(width_q);
    end
    h = (height_q == '0) ? 16'd1 : height_q;
    c = (32'(col_q) >= MAX_WIDTH) ? AW'(MAX_WIDTH - 1) : AW'(col_q);
    fire     = in_if.valid && in_ready;
    flush_in = (op_e'(in_if.opcode) == OP_FLUSH);
    ignore   = flush_in ? (pend_q == '0) : (pend_q != '0);
    final_in = flush_in && (pend_q == PW'(1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (fire) begin
          priority if (ignore) state_d = ST_IDLE;
          else if (final_in) state_d = ST_START;
          else state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        priority if (res_edge_q) state_d = ST_CALC;
        else if (res_new_q) state_d = ST_START;
        else state_d = ST_IDLE;
      end
      ST_START: state_d = ST_CALC;
      ST_CALC: begin
        if (&done && out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    start    = 1'b0;
    sel_edge = edge_q;
    lb_ctrl  = '{shift: 1'b0, wr: 1'b0, first: first_q, top_mid: topm_q, bot_mid: flush_q};
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_LOAD: begin
        lb_ctrl.shift = 1'b1;
        lb_ctrl.wr    = !flush_q;
        start         = res_edge_q;
        sel_edge      = 1'b1;
      end
      ST_START: start = 1'b1;
      ST_CALC:  out_load = &done && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // frame counters and per-item decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      pend_q     <= '0;
      res_new_q  <= 1'b0;
      res_edge_q <= 1'b0;
      edge_q     <= 1'b0;
      last_q     <= 1'b0;
      flush_q    <= 1'b0;
      first_q    <= 1'b0;
      topm_q     <= 1'b0;
    end else if (fire && !ignore) begin
      flush_q <= flush_in;
      first_q <= (c == '0);
      topm_q  <= (row_q <= 16'd1);
      if (final_in) begin
        res_new_q  <= 1'b0;
        res_edge_q <= 1'b0;
        edge_q     <= 1'b1;
        last_q     <= 1'b1;
        pend_q     <= '0;
        col_q      <= '0;
        row_q      <= '0;
      end else begin
        res_new_q  <= (c != '0) && (row_q != '0);
        res_edge_q <= (c == '0) && (row_q >= 16'd2);
        edge_q     <= 1'b0;
        last_q     <= 1'b0;
        if (flush_in) begin
          col_q  <= col_q + CW'(1);
          pend_q <= pend_q - PW'(1);
        end else if ((CW+1)'(c) + (CW+1)'(1) >= (CW+1)'(w)) begin
          col_q <= '0;
          row_q <= row_q + 16'd1;
          if (17'(row_q) + 17'd1 >= 17'(h)) begin
            pend_q <= PW'(w) + PW'(1);
          end
        end else begin
          col_q <= CW'(c) + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      addr_q <= c;
      px_q   <= {in_if.selected, in_if.pixel_in};
    end
    if (start) begin
      ctr_q <= fwin[4];
    end
  end

  sem_line_buf #(
    .MAX_WIDTH(MAX_WIDTH),
    .AW       (AW)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (fire),
    .rd_addr_i(c),
    .wr_addr_i(addr_q),
    .px_i     (px_q),
    .ctrl_i   (lb_ctrl),
    .win_o    (win)
  );

  assign fwin = sel_edge ? edge_right(win) : win;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    chan_win_t chans;
    always_comb begin
      for (int i = 0; i < 9; i++) begin
        chans[i] = fwin[i][l*8 +: 8];
      end
    end
    sem_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(start),
      .chan_i (chans),
      .sens_i (sens_q),
      .mag_o  (mag[l]),
      .done_o (done[l])
    );
  end

  // merge: centre alpha with lane magnitudes, or pass the centre through
  assign out_free = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= ctr_q[32] ? {ctr_q[31:24], mag[2], mag[1], mag[0]} : ctr_q[31:0];
      out_last_q <= last_q;
    end
  end

  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_valid_q;
  assign out_if.pixel_out     = out_pix_q;
  assign out_if.last_of_frame = out_last_q;

endmodule

[hw/rtl/sem_sva.sv]
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_filter_macros.svh"
module sem_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_pixel_i,
  input logic        out_last_i
);

  `SEM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `SEM_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_pixel_i) && $stable(out_last_i))
  `SEM_ASSERT_NXT(a_no_instant_result, clk_i, rst_ni, in_valid_i && in_ready_i, !$rose(out_valid_i))
  `SEM_ASSERT_IMP(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_i), $past(!in_ready_i))

endmodule

bind sobel_edge_magnitude_filter sem_sva u_sem_sva (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_if.valid),
  .in_ready_i (in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .out_pixel_i(out_if.pixel_out),
  .out_last_i (out_if.last_of_frame)
);
